// ===== src/bdq_pkg.sv =====
`default_nettype none
package bdq_pkg;

   localparam int VAL_W  = 32;
   localparam int KIND_W = 3;
   localparam int ST_W   = 2;
   localparam int LEN_W  = 5;

   // operation codes
   localparam logic [KIND_W-1:0] K_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] K_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] K_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] K_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] K_REMOVE     = 3'd4;
   localparam logic [KIND_W-1:0] K_READ_OUT   = 3'd5;

   // status codes
   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]         status;
      logic signed [VAL_W-1:0] entry;
      logic                    entry_valid;
      logic                    last;
      logic [LEN_W-1:0]        length;
   } rsp_type;

endpackage
`default_nettype wire

// ===== src/bdq_ram.sv =====
`default_nettype none
module bdq_ram
   import bdq_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [ADDR_W-1:0]       wr_addr,
   input  wire logic signed [VAL_W-1:0] wr_data,
   input  wire logic                    rd_en,
   input  wire logic [ADDR_W-1:0]       rd_addr,
   output logic signed [VAL_W-1:0]      rd_data
);

   logic signed [VAL_W-1:0] mem [DEPTH];
   logic signed [VAL_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low, so a stalled read-out keeps its word
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire

// ===== src/bdq_ctrl.sv =====
`default_nettype none
module bdq_ctrl
   import bdq_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int PTR_W    = 4,
   parameter int OCC_W    = 5
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire req_type                 req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output rsp_type                      rsp_data,
   output logic                         wr_en,
   output logic [PTR_W-1:0]             wr_addr,
   output logic signed [VAL_W-1:0]      wr_data,
   output logic                         rd_en,
   output logic [PTR_W-1:0]             rd_addr,
   input  wire logic signed [VAL_W-1:0] rd_data
);

   localparam int CNT_W = PTR_W + 1;
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
   localparam logic [OCC_W-1:0] CAP_O = OCC_W'(CAPACITY);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SRCH  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_READ  = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [OCC_W-1:0]        occ_ff, occ_in;
   logic [PTR_W-1:0]        idx_ff, idx_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic             free, full, empty, at_end, shift_end, load, load_entry;
   logic [ST_W-1:0]  st;
   logic [CNT_W-1:0] idx_inc, idx_inc2;

   // logical position to physical slot, ring starting at head
   function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                             input logic [PTR_W-1:0] pos);
      logic [CNT_W-1:0] s;
      s = {1'b0, head} + {1'b0, pos};
      if (s >= CAP_C) begin
         s = s - CAP_C;
      end
      return s[PTR_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] head);
      logic [PTR_W-1:0] r;
      if (head == '0) begin
         r = PTR_W'(CAPACITY - 1);
      end else begin
         r = head - PTR_W'(1);
      end
      return r;
   endfunction

   assign free      = !rsp_valid_ff || rsp_ready;
   assign full      = occ_ff == CAP_O;
   assign empty     = occ_ff == '0;
   assign idx_inc   = {1'b0, idx_ff} + CNT_W'(1);
   assign idx_inc2  = {1'b0, idx_ff} + CNT_W'(2);
   assign at_end    = idx_inc == CNT_W'(occ_ff);
   assign shift_end = idx_inc2 == CNT_W'(occ_ff);
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      occ_in     = occ_ff;
      idx_in     = idx_ff;
      value_in   = value_ff;
      wr_en      = 1'b0;
      wr_addr    = phys(head_ff, occ_ff[PTR_W-1:0]);
      wr_data    = req_data.value;
      rd_en      = 1'b0;
      rd_addr    = head_ff;
      load       = 1'b0;
      load_entry = 1'b0;
      st         = ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               value_in = req_data.value;
               idx_in   = '0;
               case (req_data.kind)
                  K_PUSH_FRONT: begin
                     load = 1'b1;
                     if (full) begin
                        st = ST_FULL;
                     end else begin
                        head_in = ring_dec(head_ff);
                        wr_en   = 1'b1;
                        wr_addr = ring_dec(head_ff);
                        occ_in  = occ_ff + OCC_W'(1);
                     end
                  end
                  K_PUSH_BACK: begin
                     load = 1'b1;
                     if (full) begin
                        st = ST_FULL;
                     end else begin
                        wr_en  = 1'b1;
                        occ_in = occ_ff + OCC_W'(1);
                     end
                  end
                  K_POP_FRONT: begin
                     load = 1'b1;
                     if (empty) begin
                        st = ST_EMPTY;
                     end else begin
                        head_in = phys(head_ff, PTR_W'(1));
                        occ_in  = occ_ff - OCC_W'(1);
                     end
                  end
                  K_POP_BACK: begin
                     load = 1'b1;
                     if (empty) begin
                        st = ST_EMPTY;
                     end else begin
                        occ_in = occ_ff - OCC_W'(1);
                     end
                  end
                  K_REMOVE: begin
                     if (empty) begin
                        load = 1'b1;
                        st   = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_SRCH;
                     end
                  end
                  K_READ_OUT: begin
                     if (empty) begin
                        load = 1'b1;
                        st   = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         S_SRCH: begin
            // rd_data holds the entry at idx_ff
            if (rd_data == value_ff) begin
               if (at_end) begin
                  occ_in   = occ_ff - OCC_W'(1);
                  load     = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = phys(head_ff, idx_inc[PTR_W-1:0]);
                  state_in = S_SHIFT;
               end
            end else if (at_end) begin
               load     = 1'b1;
               st       = ST_NOT_FOUND;
               state_in = S_IDLE;
            end else begin
               idx_in  = idx_inc[PTR_W-1:0];
               rd_en   = 1'b1;
               rd_addr = phys(head_ff, idx_inc[PTR_W-1:0]);
            end
         end
         S_SHIFT: begin
            // close the gap: entry idx+1 moves down to idx
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, idx_ff);
            wr_data = rd_data;
            idx_in  = idx_inc[PTR_W-1:0];
            if (shift_end) begin
               occ_in   = occ_ff - OCC_W'(1);
               load     = 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = phys(head_ff, idx_inc2[PTR_W-1:0]);
            end
         end
         S_READ: begin
            if (free) begin
               load       = 1'b1;
               load_entry = 1'b1;
               if (at_end) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in  = idx_inc[PTR_W-1:0];
                  rd_en   = 1'b1;
                  rd_addr = phys(head_ff, idx_inc[PTR_W-1:0]);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = st;
         rsp_in.entry       = load_entry ? rd_data : '0;
         rsp_in.entry_valid = load_entry;
         rsp_in.last        = load_entry ? at_end : 1'b1;
         rsp_in.length      = LEN_W'(occ_in);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== src/bounded_deque_with_remove_by_value_unit.sv =====
`default_nettype none
// Bounded deque of up to CAPACITY signed 32-bit values, held as a ring in a
// single-port-write, registered-read RAM with a head pointer and a count.
// Push front/back and pop front/back answer with one status transfer.
// Remove-by-value walks the list front first, one entry per cycle through
// the RAM read port and a single comparator, then closes the gap one entry
// per cycle from the match onwards: walk and gap closing together visit
// every entry held, matched or not, before the status transfer. Read-out
// returns one transfer per entry, one per cycle while rsp_ready stays high,
// the last one flagged. The next request is taken once the final response
// has been transferred. No clearing pass after reset.
module bounded_deque_with_remove_by_value_unit
   import bdq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int OCC_W = $clog2(CAPACITY + 1);

   logic                    wr_en, rd_en;
   logic [PTR_W-1:0]        wr_addr, rd_addr;
   logic signed [VAL_W-1:0] wr_data, rd_data;

   bdq_ctrl #(
      .CAPACITY (CAPACITY),
      .PTR_W    (PTR_W),
      .OCC_W    (OCC_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   bdq_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

`ifndef SYNTHESIS
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in progress");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_valid || rsp_data.last)
      else $error("status response not marked last");

   a_entry_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_valid |-> rsp_data.status == ST_OK)
      else $error("read-out entry with non-ok status");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.length <= LEN_W'(CAPACITY) || CAPACITY > 31)
      else $error("length beyond capacity");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import bdq_pkg::*;

   localparam int CAPACITY       = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int PHASE_ITEMS    = 25;

   // kind codes the block must ignore
   localparam logic [KIND_W-1:0] K_SPARE_6 = 3'd6;
   localparam logic [KIND_W-1:0] K_SPARE_7 = 3'd7;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;

   class deque_scoreboard;
      logic signed [VAL_W-1:0] held[$];
      rsp_type                 expected_rsp[$];
      int                      errors = 0;

      function void push_status(logic [ST_W-1:0] st);
         rsp_type r;
         r        = '0;
         r.status = st;
         r.last   = 1'b1;
         r.length = LEN_W'(held.size());
         expected_rsp.push_back(r);
      endfunction

      function void note_request(req_type item);
         int      pos;
         rsp_type r;
         case (item.kind)
            K_PUSH_FRONT, K_PUSH_BACK: begin
               if (held.size() >= CAPACITY) begin
                  push_status(ST_FULL);
               end else begin
                  if (item.kind == K_PUSH_FRONT) held.push_front(item.value);
                  else held.push_back(item.value);
                  push_status(ST_OK);
               end
            end
            K_POP_FRONT, K_POP_BACK: begin
               if (held.size() == 0) begin
                  push_status(ST_EMPTY);
               end else begin
                  if (item.kind == K_POP_FRONT) void'(held.pop_front());
                  else void'(held.pop_back());
                  push_status(ST_OK);
               end
            end
            K_REMOVE: begin
               if (held.size() == 0) begin
                  push_status(ST_EMPTY);
               end else begin
                  pos = -1;
                  // first match from the front only
                  for (int i = 0; i < held.size(); i++)
                     if (pos < 0 && held[i] == item.value) pos = i;
                  if (pos < 0) begin
                     push_status(ST_NOT_FOUND);
                  end else begin
                     held.delete(pos);
                     push_status(ST_OK);
                  end
               end
            end
            K_READ_OUT: begin
               if (held.size() == 0) begin
                  push_status(ST_EMPTY);
               end else begin
                  foreach (held[i]) begin
                     r             = '0;
                     r.status      = ST_OK;
                     r.entry       = held[i];
                     r.entry_valid = 1'b1;
                     r.last        = (i == held.size() - 1);
                     r.length      = LEN_W'(held.size());
                     expected_rsp.push_back(r);
                  end
               end
            end
            default: push_status(ST_OK);
         endcase
      endfunction

      task report(string what);
         errors++;
         if (errors <= 50) $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            report($sformatf("transfer with nothing expected, entry %0d", got.entry));
            return;
         end
         want = expected_rsp.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.entry !== want.entry)
            report($sformatf("entry %0d, want %0d", got.entry, want.entry));
         if (got.entry_valid !== want.entry_valid)
            report($sformatf("entry_valid %0b, want %0b", got.entry_valid, want.entry_valid));
         if (got.last !== want.last)
            report($sformatf("last %0b, want %0b", got.last, want.last));
         if (got.length !== want.length)
            report($sformatf("length %0d, want %0d", got.length, want.length));
      endtask

      function int outstanding();
         return expected_rsp.size();
      endfunction
   endclass

   deque_scoreboard board = new();

   bounded_deque_with_remove_by_value_unit #(
      .CAPACITY (CAPACITY)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // both channels sampled together so a request is noted before its answer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_data);
         if (rsp_valid && rsp_ready) board.check_response(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** bounded_deque_with_remove_by_value_unit: FAILED **");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic issue(input logic [KIND_W-1:0] kind, input logic signed [VAL_W-1:0] value);
      req_type item;
      item.kind  = kind;
      item.value = value;
      // valid drops only when a gap is taken, never in the step it rises again
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic signed [VAL_W-1:0] random_value();
      case ($urandom_range(9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         4:       return 32'sh0000_0007;
         default: return $urandom;
      endcase
   endfunction

   // mostly aim removes at something held so the walk and gap closing run
   function automatic logic signed [VAL_W-1:0] remove_target();
      if (board.held.size() != 0 && $urandom_range(99) < 65)
         return board.held[$urandom_range(board.held.size() - 1)];
      return random_value();
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind(bit filling);
      int roll;
      roll = $urandom_range(99);
      if (filling) begin
         if (roll < 40) return K_PUSH_FRONT;
         if (roll < 85) return K_PUSH_BACK;
         if (roll < 88) return K_POP_FRONT;
         if (roll < 91) return K_POP_BACK;
         if (roll < 95) return K_REMOVE;
         if (roll < 98) return K_READ_OUT;
      end else begin
         if (roll < 10) return K_PUSH_FRONT;
         if (roll < 20) return K_PUSH_BACK;
         if (roll < 40) return K_POP_FRONT;
         if (roll < 60) return K_POP_BACK;
         if (roll < 85) return K_REMOVE;
         if (roll < 98) return K_READ_OUT;
      end
      return (roll == 98) ? K_SPARE_6 : K_SPARE_7;
   endfunction

   initial begin
      logic [KIND_W-1:0] kind;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty list corner cases
      issue(K_READ_OUT, 32'sd1);
      issue(K_POP_FRONT, 32'sd2);
      issue(K_POP_BACK, 32'sd3);
      issue(K_REMOVE, 32'sd0);
      issue(K_SPARE_6, 32'sh7FFF_FFFF);
      issue(K_SPARE_7, 32'sh8000_0000);
      // extremes at both ends, duplicate of the largest value
      issue(K_PUSH_BACK, 32'sh7FFF_FFFF);
      issue(K_PUSH_FRONT, 32'sh8000_0000);
      issue(K_PUSH_BACK, 32'sd0);
      issue(K_PUSH_FRONT, -32'sd1);
      issue(K_PUSH_BACK, 32'sh7FFF_FFFF);
      issue(K_READ_OUT, 32'sd0);
      issue(K_REMOVE, 32'sh7FFF_FFFF);
      issue(K_REMOVE, 32'sd12345);
      issue(K_SPARE_6, 32'sd0);
      issue(K_POP_FRONT, 32'sd0);
      issue(K_POP_BACK, 32'sd0);
      issue(K_READ_OUT, 32'sd0);

      // even phases fill past capacity, odd phases drain towards empty
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            kind = pick_kind(ph % 2 == 0);
            issue(kind, (kind == K_REMOVE) ? remove_target() : random_value());
         end
      end
      req_valid <= 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.outstanding() == 0)
         $display("** bounded_deque_with_remove_by_value_unit: PASSED **");
      else
         $display("** bounded_deque_with_remove_by_value_unit: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
src/bdq_pkg.sv
src/bdq_ram.sv
src/bdq_ctrl.sv
src/bounded_deque_with_remove_by_value_unit.sv
tb/tb_top.sv
